// ----- rtl/wph_pkg.sv -----
// ============================================================================
// wph_pkg: shared types and constants of the weighted particle histogram
// Sizes of the bin store, configuration register map, controller states
// and the command/status bundles between controller and datapath.
// ============================================================================
package wph_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LIM_W    = 9;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        FUNC_ADD,
        FUNC_READ_BIN,
        FUNC_READ_SUMS,
        FUNC_NONE
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_INV_STEP_X,
        CFG_INV_STEP_Y,
        CFG_ROW_COUNT,
        CFG_COL_COUNT,
        CFG_BIN_VELOCITY
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [23:0]        inv_step_x;
        logic [23:0]        inv_step_y;
        logic [6:0]         row_count;
        logic [6:0]         col_count;
        logic               bin_velocity;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_LOCATE,
        ST_UPDATE,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_SUMS,
        ST_NOP
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic mul;
        logic locate;
        logic bin_update;
        logic bin_read;
        logic bin_flush;
        logic sums_out;
        logic none_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

// ----- rtl/wph_cfg.sv -----
// ============================================================================
// wph_cfg: configuration register file
// Takes register writes by index; unknown indexes are dropped.
// ============================================================================
module wph_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    output wph_pkg::cfg_t                    cfg
);
    import wph_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:     cfg_next.origin_x     = cfg_data;
                CFG_ORIGIN_Y:     cfg_next.origin_y     = cfg_data;
                CFG_INV_STEP_X:   cfg_next.inv_step_x   = cfg_data[23:0];
                CFG_INV_STEP_Y:   cfg_next.inv_step_y   = cfg_data[23:0];
                CFG_ROW_COUNT:    cfg_next.row_count    = cfg_data[6:0];
                CFG_COL_COUNT:    cfg_next.col_count    = cfg_data[6:0];
                CFG_BIN_VELOCITY: cfg_next.bin_velocity = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= 32'sd0;
            cfg_reg.origin_y     <= 32'sd0;
            cfg_reg.inv_step_x   <= 24'd65536;
            cfg_reg.inv_step_y   <= 24'd65536;
            cfg_reg.row_count    <= 7'd64;
            cfg_reg.col_count    <= 7'd64;
            cfg_reg.bin_velocity <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/wph_ctrl.sv -----
// ============================================================================
// wph_ctrl: sequencing controller
// Sweeps the bin store clear after reset, then steps each command through
// the datapath and drives busy.
// ============================================================================
module wph_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           func,
    output logic                 busy,
    output wph_pkg::dp_cmd_t     cmd,
    input  wph_pkg::dp_status_t  status
);
    import wph_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (func_t'(func))
                        FUNC_ADD:       state_next = ST_MUL;
                        FUNC_READ_BIN:  state_next = ST_BIN_RD;
                        FUNC_READ_SUMS: state_next = ST_SUMS;
                        FUNC_NONE:      state_next = ST_NOP;
                    endcase
                end
            end
            ST_MUL:    state_next = ST_LOCATE;
            ST_LOCATE: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            ST_BIN_RD: state_next = ST_BIN_WR;
            ST_BIN_WR: state_next = ST_IDLE;
            ST_SUMS:   state_next = ST_IDLE;
            ST_NOP:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        busy           = (state_reg != ST_IDLE);
        cmd.capture    = (state_reg == ST_IDLE) && start;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.locate     = (state_reg == ST_LOCATE);
        cmd.bin_update = (state_reg == ST_UPDATE);
        cmd.bin_read   = (state_reg == ST_BIN_RD);
        cmd.bin_flush  = (state_reg == ST_BIN_WR);
        cmd.sums_out   = (state_reg == ST_SUMS);
        cmd.none_out   = (state_reg == ST_NOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/wph_dp.sv -----
// ============================================================================
// wph_dp: histogram datapath
// Bin index multipliers, weighted sum lanes, the bin store memory with its
// clear sweep, and the registered result fields.
// ============================================================================
module wph_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wph_pkg::dp_cmd_t     cmd,
    output wph_pkg::dp_status_t  status,
    input  wph_pkg::cfg_t        cfg,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic [16:0]          weight,
    input  logic [6:0]           bin_row,
    input  logic [6:0]           bin_col,
    output logic                 done,
    output logic [31:0]          bin_weight,
    output logic                 binned,
    output logic signed [31:0]   mean_pos_x,
    output logic signed [31:0]   mean_pos_y,
    output logic signed [31:0]   mean_pos_z,
    output logic signed [31:0]   mean_vel_x,
    output logic signed [31:0]   mean_vel_y,
    output logic signed [31:0]   mean_vel_z
);
    import wph_pkg::*;

    localparam logic signed [57:0] HALF_LSB = 58'sh80000000;

    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    // Q32.32 sum to Q16.16, rounded half away from zero, clipped to 32 bits
    function automatic logic [31:0] sum_round(input logic signed [63:0] s);
        logic [63:0] mag;
        logic [63:0] rnd;
        logic [47:0] q;
        logic [47:0] neg_q;
        mag = s[63] ? (~s + 64'd1) : s;
        rnd = mag + 64'h8000;
        q   = rnd[63:16];
        if (s[63])
        begin
            if (q > 48'h80000000)
                q = 48'h80000000;
            neg_q = ~q + 48'd1;
            return neg_q[31:0];
        end
        if (q > 48'h7FFFFFFF)
            q = 48'h7FFFFFFF;
        return q[31:0];
    endfunction

    // captured item
    logic signed [32:0] rel_x_reg;
    logic signed [32:0] rel_y_reg;
    logic signed [31:0] term_reg [6];
    logic [16:0]        weight_reg;
    logic [6:0]         row_reg;
    logic [6:0]         col_reg;

    // multiplier stage
    logic signed [57:0] prod_x_reg;
    logic signed [57:0] prod_y_reg;
    logic signed [49:0] wprod_reg [6];

    // accumulators
    logic signed [63:0] sum_reg [6];

    // bin store
    logic [31:0]        mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // results
    logic               done_reg;
    logic [31:0]        bin_weight_reg;
    logic               binned_reg;
    logic signed [31:0] mean_reg [6];

    logic signed [31:0] sel_x;
    logic signed [31:0] sel_y;
    logic signed [24:0] inv_x_s;
    logic signed [24:0] inv_y_s;
    logic signed [17:0] weight_s;
    logic signed [57:0] rnd_x;
    logic signed [57:0] rnd_y;
    logic [25:0]        idx_x;
    logic [25:0]        idx_y;
    logic [LIM_W-1:0]   rows_use;
    logic [LIM_W-1:0]   cols_use;
    logic               ok_x;
    logic               ok_y;
    logic [ROW_W-1:0]   row0_add;
    logic [COL_W-1:0]   col0_add;
    logic [ADDR_W-1:0]  addr_add;
    logic               bin_ok;
    logic [ROW_W-1:0]   row0_bin;
    logic [COL_W-1:0]   col0_bin;
    logic [ADDR_W-1:0]  addr_bin;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [32:0]        bin_sum;
    logic [31:0]        wr_data;
    logic               out_load;

    // ---------------------------------------------------------------- capture
    assign sel_x = cfg.bin_velocity ? vel_x : pos_x;
    assign sel_y = cfg.bin_velocity ? vel_y : pos_y;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rel_x_reg   <= 33'(sel_x) - 33'(cfg.origin_x);
            rel_y_reg   <= 33'(sel_y) - 33'(cfg.origin_y);
            term_reg[0] <= pos_x;
            term_reg[1] <= pos_y;
            term_reg[2] <= pos_z;
            term_reg[3] <= vel_x;
            term_reg[4] <= vel_y;
            term_reg[5] <= vel_z;
            weight_reg  <= weight;
            row_reg     <= bin_row;
            col_reg     <= bin_col;
        end
    end

    // ------------------------------------------------------------- multiplier
    assign inv_x_s  = $signed({1'b0, cfg.inv_step_x});
    assign inv_y_s  = $signed({1'b0, cfg.inv_step_y});
    assign weight_s = $signed({1'b0, weight_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_x_reg <= rel_x_reg * inv_x_s;
            prod_y_reg <= rel_y_reg * inv_y_s;
            for (int i = 0; i < 6; i++)
                wprod_reg[i] <= term_reg[i] * weight_s;
        end
    end

    // -------------------------------------------------------------- bin index
    assign rnd_x = prod_x_reg + HALF_LSB;
    assign rnd_y = prod_y_reg + HALF_LSB;
    assign idx_x = rnd_x[57:32];
    assign idx_y = rnd_y[57:32];

    assign rows_use = (LIM_W'(cfg.row_count) < LIM_W'(MAX_ROWS)) ?
                      LIM_W'(cfg.row_count) : LIM_W'(MAX_ROWS);
    assign cols_use = (LIM_W'(cfg.col_count) < LIM_W'(MAX_COLS)) ?
                      LIM_W'(cfg.col_count) : LIM_W'(MAX_COLS);

    assign ok_x = !prod_x_reg[57] && (prod_x_reg != 58'sd0) && (idx_x != 26'd0)
                  && (idx_x <= 26'(rows_use));
    assign ok_y = !prod_y_reg[57] && (prod_y_reg != 58'sd0) && (idx_y != 26'd0)
                  && (idx_y <= 26'(cols_use));

    assign row0_add = ROW_W'(idx_x - 26'd1);
    assign col0_add = COL_W'(idx_y - 26'd1);
    assign addr_add = ADDR_W'(row0_add * MAX_COLS + col0_add);

    assign bin_ok = (row_reg != 7'd0) && (LIM_W'(row_reg) <= LIM_W'(MAX_ROWS))
                    && (col_reg != 7'd0) && (LIM_W'(col_reg) <= LIM_W'(MAX_COLS));
    assign row0_bin = ROW_W'(row_reg - 7'd1);
    assign col0_bin = COL_W'(col_reg - 7'd1);
    assign addr_bin = ADDR_W'(row0_bin * MAX_COLS + col0_bin);

    always_ff @(posedge clk)
    begin
        if (cmd.locate)
        begin
            hit_reg  <= ok_x && ok_y;
            addr_reg <= addr_add;
        end
        else if (cmd.bin_read)
        begin
            hit_reg  <= bin_ok;
            addr_reg <= addr_bin;
        end
    end

    // -------------------------------------------------------------- bin store
    assign rd_addr = cmd.locate ? addr_add : addr_bin;
    assign bin_sum = 33'(rd_data_reg) + 33'(weight_reg);
    assign mem_we  = cmd.clear_step || ((cmd.bin_update || cmd.bin_flush) && hit_reg);
    assign wr_addr = cmd.clear_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.bin_update ? (bin_sum[32] ? 32'hFFFFFFFF : bin_sum[31:0])
                                    : 32'd0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (cmd.locate || cmd.bin_read)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_step)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    // ------------------------------------------------------------ accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                sum_reg[i] <= 64'sd0;
        end
        else if (cmd.sums_out)
        begin
            for (int i = 0; i < 6; i++)
                sum_reg[i] <= 64'sd0;
        end
        else if (cmd.locate)
        begin
            for (int i = 0; i < 6; i++)
                sum_reg[i] <= sat_add64(sum_reg[i], 64'(wprod_reg[i]));
        end
    end

    // ----------------------------------------------------------------- result
    assign out_load = cmd.bin_update || cmd.bin_flush || cmd.sums_out || cmd.none_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= out_load;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            binned_reg     <= cmd.bin_update && hit_reg;
            bin_weight_reg <= (cmd.bin_flush && hit_reg) ? rd_data_reg : 32'd0;
            for (int i = 0; i < 6; i++)
                mean_reg[i] <= cmd.sums_out ? sum_round(sum_reg[i]) : 32'sd0;
        end
    end

    assign done       = done_reg;
    assign binned     = binned_reg;
    assign bin_weight = bin_weight_reg;
    assign mean_pos_x = mean_reg[0];
    assign mean_pos_y = mean_reg[1];
    assign mean_pos_z = mean_reg[2];
    assign mean_vel_x = mean_reg[3];
    assign mean_vel_y = mean_reg[4];
    assign mean_vel_z = mean_reg[5];

endmodule

// ----- rtl/weighted_particle_histogram_unit.sv -----
// ============================================================================
// weighted_particle_histogram_unit: weighted 2-D particle histogram
// Add particle: multiply, locate and read the bin, then write the bin back
//   through one memory port; a new start is taken only once the unit is idle again.
// Read bin: read, then clear the entry. Read sums or func 3 go straight to the result.
// After reset busy stays high while the whole bin store is swept to zero;
// configuration writes are taken during the sweep. Results cannot stall.
// ============================================================================
module weighted_particle_histogram_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       func,
    input  logic signed [31:0]               pos_x,
    input  logic signed [31:0]               pos_y,
    input  logic signed [31:0]               pos_z,
    input  logic signed [31:0]               vel_x,
    input  logic signed [31:0]               vel_y,
    input  logic signed [31:0]               vel_z,
    input  logic [16:0]                      weight,
    input  logic [6:0]                       bin_row,
    input  logic [6:0]                       bin_col,
    output logic                             done,
    output logic [31:0]                      bin_weight,
    output logic                             binned,
    output logic signed [31:0]               mean_pos_x,
    output logic signed [31:0]               mean_pos_y,
    output logic signed [31:0]               mean_pos_z,
    output logic signed [31:0]               mean_vel_x,
    output logic signed [31:0]               mean_vel_y,
    output logic signed [31:0]               mean_vel_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import wph_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    wph_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wph_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    wph_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .weight     (weight),
        .bin_row    (bin_row),
        .bin_col    (bin_col),
        .done       (done),
        .bin_weight (bin_weight),
        .binned     (binned),
        .mean_pos_x (mean_pos_x),
        .mean_pos_y (mean_pos_y),
        .mean_pos_z (mean_pos_z),
        .mean_vel_x (mean_vel_x),
        .mean_vel_y (mean_vel_y),
        .mean_vel_z (mean_vel_z)
    );

endmodule

// ----- rtl/wph_checker.sv -----
// ============================================================================
// wph_checker: port-level checks of the histogram unit
// Watches the command handshake and the result strobe over time.
// ============================================================================
module wph_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               binned,
    input logic [31:0]        bin_weight,
    input logic signed [31:0] mean_pos_x
);

    // an accepted command keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // the unit returns to idle between commands, so results never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a result strobe is only raised after the unit was busy
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without prior busy");

    // an add result that landed in a bin carries no bin content and a zero mean_pos_x
    a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && binned) |-> ((bin_weight == 32'd0) && (mean_pos_x == 32'sd0)))
        else $error("add result carries read fields");

endmodule

bind weighted_particle_histogram_unit wph_checker u_wph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .binned     (binned),
    .bin_weight (bin_weight),
    .mean_pos_x (mean_pos_x)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench of weighted_particle_histogram_unit
// Drives particle adds, bin reads and sum reads through the start/busy port.
// Every result is checked against an in-bench model of the bin store and of
// the weighted sums. The run covers several register settings, bins outside
// the area in use, clipping of the sum readout, and random idle gaps on the
// command side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wph_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int BURST_ADDS  = 24;
    localparam int PHASE_ITEMS = 85;
    localparam int REPORT_MAX  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [31:0] HALF = 32'h0000_8000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    typedef struct {
        func_t              op;
        logic [2:0][31:0]   pos;
        logic [2:0][31:0]   vel;
        logic [16:0]        weight;
        logic [6:0]         row;
        logic [6:0]         col;
        int                 gap;
    } particle_cmd_t;

    typedef struct packed {
        logic [31:0]        bin_weight;
        logic               binned;
        logic [5:0][31:0]   means;
    } histo_answer_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         func = FUNC_NONE;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic signed [31:0] vel_x = '0;
    logic signed [31:0] vel_y = '0;
    logic signed [31:0] vel_z = '0;
    logic [16:0]        weight = '0;
    logic [6:0]         bin_row = '0;
    logic [6:0]         bin_col = '0;
    logic               done;
    logic [31:0]        bin_weight;
    logic               binned;
    logic signed [31:0] mean_pos_x;
    logic signed [31:0] mean_pos_y;
    logic signed [31:0] mean_pos_z;
    logic signed [31:0] mean_vel_x;
    logic signed [31:0] mean_vel_y;
    logic signed [31:0] mean_vel_z;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // register mirror
    logic signed [31:0] org_x = '0;
    logic signed [31:0] org_y = '0;
    logic [23:0]        step_x = 24'h010000;
    logic [23:0]        step_y = 24'h010000;
    logic [6:0]         rows_reg = 7'd64;
    logic [6:0]         cols_reg = 7'd64;
    logic               vel_mode = 1'b0;

    // model state
    logic [31:0]        bin_model [MAX_ROWS*MAX_COLS];
    longint             pos_acc [3];
    longint             vel_acc [3];

    particle_cmd_t      particle_cmds [$];
    histo_answer_t      answers_due [$];
    particle_cmd_t      cur_cmd;
    int                 target_rows [$];
    int                 target_cols [$];

    int                 gap_left = 0;
    bit                 gap_armed = 1'b0;
    int                 burst_left = 0;
    int                 issued = 0;
    int                 accepted = 0;
    int                 results_seen = 0;
    int                 bins_hit = 0;
    int                 mismatches = 0;
    int                 reg_writes = 0;
    int                 settings_used = 0;
    int                 cycle_count = 0;

    string MEAN_NAMES [6] = '{"mean_pos_x", "mean_pos_y", "mean_pos_z",
                              "mean_vel_x", "mean_vel_y", "mean_vel_z"};

    weighted_particle_histogram_unit dut (.*);

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------
    function automatic longint axis_bin(logic [31:0] p, logic [31:0] org,
                                        logic [23:0] step);
        longint prod;
        prod = (longint'($signed(p)) - longint'($signed(org))) * longint'(step);
        if (prod <= 0)
            return 0;
        return (prod + 64'sh8000_0000) >>> 32;
    endfunction

    function automatic longint sat_acc(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    // Q32.32 sum to Q16.16, rounded half away from zero, clipped to 32 bits
    function automatic logic [31:0] q16_round(longint s);
        logic [63:0] mag;
        mag = s[63] ? -s : s;
        mag = (mag + 64'h8000) >> 16;
        if (s[63])
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return -mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic histo_answer_t bin_and_accumulate(particle_cmd_t c);
        histo_answer_t a;
        longint r;
        longint k;
        int rows_used;
        int cols_used;
        int addr;
        logic [32:0] total;
        a = '0;
        case (c.op)
            FUNC_ADD:
            begin
                rows_used = rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg;
                cols_used = cols_reg > MAX_COLS ? MAX_COLS : cols_reg;
                r = axis_bin(vel_mode ? c.vel[0] : c.pos[0], org_x, step_x);
                k = axis_bin(vel_mode ? c.vel[1] : c.pos[1], org_y, step_y);
                if (r != 0 && k != 0 && r <= rows_used && k <= cols_used)
                begin
                    addr = int'((r - 1) * MAX_COLS + (k - 1));
                    total = {1'b0, bin_model[addr]} + c.weight;
                    bin_model[addr] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                    a.binned = 1'b1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    pos_acc[i] = sat_acc(pos_acc[i],
                                         longint'($signed(c.pos[i])) * longint'(c.weight));
                    vel_acc[i] = sat_acc(vel_acc[i],
                                         longint'($signed(c.vel[i])) * longint'(c.weight));
                end
            end
            FUNC_READ_BIN:
            begin
                if (c.row >= 1 && c.row <= MAX_ROWS && c.col >= 1 && c.col <= MAX_COLS)
                begin
                    addr = (c.row - 1) * MAX_COLS + (c.col - 1);
                    a.bin_weight = bin_model[addr];
                    bin_model[addr] = '0;
                end
            end
            FUNC_READ_SUMS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a.means[i] = q16_round(pos_acc[i]);
                    a.means[3 + i] = q16_round(vel_acc[i]);
                    pos_acc[i] = 0;
                    vel_acc[i] = 0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            burst_left = 25;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [16:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 17'h10000;
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic particle_cmd_t blank_cmd(func_t op);
        particle_cmd_t c;
        c.op = op;
        for (int i = 0; i < 3; i++)
        begin
            c.pos[i] = $urandom;
            c.vel[i] = $urandom;
        end
        c.weight = pick_weight();
        c.row = 7'($urandom);
        c.col = 7'($urandom);
        c.gap = idle_len();
        return c;
    endfunction

    function automatic particle_cmd_t particle(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [31:0] vx,
                                               logic [31:0] vy, logic [31:0] vz,
                                               logic [16:0] w);
        particle_cmd_t c;
        c = blank_cmd(FUNC_ADD);
        c.pos = {pz, py, px};
        c.vel = {vz, vy, vx};
        c.weight = w;
        return c;
    endfunction

    function automatic particle_cmd_t bin_read(logic [6:0] r, logic [6:0] k);
        particle_cmd_t c;
        c = blank_cmd(FUNC_READ_BIN);
        c.row = r;
        c.col = k;
        return c;
    endfunction

    // coordinate that lands near bin k along one axis
    function automatic logic [31:0] aim(int k, logic signed [31:0] org, logic [23:0] step);
        longint rel;
        if (step == 0)
            return $urandom;
        rel = ((longint'(k) <<< 32) + longint'($urandom) - 64'sh8000_0000)
              / longint'(step);
        return 32'(longint'(org) + rel);
    endfunction

    function automatic void enqueue(particle_cmd_t c);
        particle_cmds.insert(particle_cmds.size(), c);
        issued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:     org_x = data;
            CFG_ORIGIN_Y:     org_y = data;
            CFG_INV_STEP_X:   step_x = data[23:0];
            CFG_INV_STEP_Y:   step_y = data[23:0];
            CFG_ROW_COUNT:    rows_reg = data[6:0];
            CFG_COL_COUNT:    cols_reg = data[6:0];
            CFG_BIN_VELOCITY: vel_mode = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                             logic [31:0] sy, logic [31:0] nr, logic [31:0] nc,
                             logic [31:0] vm);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_INV_STEP_X, sx);
        write_reg(CFG_INV_STEP_Y, sy);
        write_reg(CFG_ROW_COUNT, nr);
        write_reg(CFG_COL_COUNT, nc);
        write_reg(CFG_BIN_VELOCITY, vm);
        settings_used++;
    endtask

    // hold until every command is taken and every answer is back
    task automatic settle();
        while (accepted != issued || answers_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        particle_cmd_t c;
        int unsigned sel;
        int unsigned pick;
        int rows_used;
        int cols_used;
        int kr;
        int kc;
        target_rows.delete();
        target_cols.delete();
        rows_used = rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg;
        cols_used = cols_reg > MAX_COLS ? MAX_COLS : cols_reg;
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 62)
            begin
                c = blank_cmd(FUNC_ADD);
                kr = int'($urandom_range(0, rows_used + 3)) - 1;
                kc = int'($urandom_range(0, cols_used + 3)) - 1;
                if (vel_mode)
                begin
                    c.vel[0] = aim(kr, org_x, step_x);
                    c.vel[1] = aim(kc, org_y, step_y);
                end
                else
                begin
                    c.pos[0] = aim(kr, org_x, step_x);
                    c.pos[1] = aim(kc, org_y, step_y);
                end
                if (kr >= 1 && kr <= rows_used && kc >= 1 && kc <= cols_used)
                begin
                    target_rows.insert(target_rows.size(), kr);
                    target_cols.insert(target_cols.size(), kc);
                end
            end
            else if (sel < 74 && target_rows.size() != 0)
            begin
                pick = $urandom_range(0, target_rows.size() - 1);
                c = bin_read(7'(target_rows[pick]), 7'(target_cols[pick]));
            end
            else if (sel < 79)
                c = blank_cmd(FUNC_READ_BIN);
            else if (sel < 86)
                c = blank_cmd(FUNC_READ_SUMS);
            else if (sel < 96)
                c = blank_cmd(FUNC_ADD);
            else
                c = blank_cmd(FUNC_NONE);
            enqueue(c);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic launch;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
            gap_armed = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                answers_due.insert(answers_due.size(), bin_and_accumulate(cur_cmd));
                accepted++;
            end
            if (!start || !busy)
            begin
                launch = 1'b0;
                if (particle_cmds.size() != 0)
                begin
                    if (!gap_armed)
                    begin
                        gap_left = particle_cmds[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        cur_cmd = particle_cmds.pop_front();
                        gap_armed = 1'b0;
                        launch = 1'b1;
                        func    <= cur_cmd.op;
                        pos_x   <= cur_cmd.pos[0];
                        pos_y   <= cur_cmd.pos[1];
                        pos_z   <= cur_cmd.pos[2];
                        vel_x   <= cur_cmd.vel[0];
                        vel_y   <= cur_cmd.vel[1];
                        vel_z   <= cur_cmd.vel[2];
                        weight  <= cur_cmd.weight;
                        bin_row <= cur_cmd.row;
                        bin_col <= cur_cmd.col;
                    end
                end
                start <= launch;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("MISMATCH at result %0d: %s", results_seen, msg);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    always @(posedge clk)
    begin
        histo_answer_t got;
        histo_answer_t want;
        if (rst_n && done)
        begin
            results_seen++;
            got.bin_weight = bin_weight;
            got.binned = binned;
            got.means = {mean_vel_z, mean_vel_y, mean_vel_x,
                         mean_pos_z, mean_pos_y, mean_pos_x};
            if (answers_due.size() == 0)
                note_mismatch($sformatf("unexpected result bin_weight=%h binned=%b",
                                        bin_weight, binned));
            else
            begin
                want = answers_due.pop_front();
                if (want.binned)
                    bins_hit++;
                check_field("bin_weight", want.bin_weight, got.bin_weight);
                check_field("binned", 32'(want.binned), 32'(got.binned));
                for (int i = 0; i < 6; i++)
                    check_field(MEAN_NAMES[i], want.means[i], got.means[i]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d of %0d commands taken, %0d answers due",
                     cycle_count, accepted, issued, answers_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        particle_cmd_t c;
        foreach (bin_model[i])
            bin_model[i] = '0;
        for (int i = 0; i < 3; i++)
        begin
            pos_acc[i] = 0;
            vel_acc[i] = 0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: origin 0, unit bins, 64 x 64, binning on position
        enqueue(particle(HALF, HALF, 0, 0, 0, 0, 17'h10000));          // rounds up to 1,1
        enqueue(particle(32'h7FFF, HALF, 0, 0, 0, 0, 17'h10000));      // rounds to 0
        enqueue(particle(64 * ONE + 32'h7FFF, 64 * ONE + 32'h7FFF, 0, 0, 0, 0, 17'h1FFFF));
        enqueue(particle(64 * ONE + HALF, ONE, 0, 0, 0, 0, 17'h10000)); // row 65
        enqueue(particle(-HALF, ONE, 0, 0, 0, 0, 17'h10000));            // negative
        enqueue(blank_cmd(FUNC_READ_SUMS));
        // sums of plus and minus half an LSB round away from zero
        enqueue(particle(32'h1, 32'hFFFF_FFFF, 0, 32'h1, 32'hFFFF_FFFF, 0, 17'h08000));
        enqueue(blank_cmd(FUNC_READ_SUMS));
        enqueue(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'h1FFFF));
        enqueue(blank_cmd(FUNC_READ_SUMS));
        enqueue(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF));
        enqueue(blank_cmd(FUNC_READ_SUMS));
        enqueue(particle(HALF, HALF, 0, 0, 0, 0, 17'h0));
        enqueue(bin_read(7'd1, 7'd1));
        enqueue(bin_read(7'd64, 7'd64));
        enqueue(bin_read(7'd1, 7'd1));
        enqueue(bin_read(7'd0, 7'd5));
        enqueue(bin_read(7'd65, 7'd1));
        enqueue(bin_read(7'd127, 7'd127));
        enqueue(bin_read(7'd1, 7'd0));
        enqueue(blank_cmd(FUNC_NONE));
        settle();

        configure(32'hFFFB_0000, 32'h0003_4000, 32'h0002_0000, 32'h0000_8000,
                  32'd10, 32'd20, 32'd0);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        // extreme origins and steps; upper data bits must be dropped
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF,
                  32'hFFFF_FFFF, 32'd127, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        // zero step on x and zero rows: nothing may land in a bin
        configure(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd0, 32'd64, 32'd0);
        random_phase(PHASE_ITEMS);

        configure(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
                  32'd1, 32'd1, 32'd1);
        random_phase(PHASE_ITEMS);

        repeat (2)
        begin
            configure($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                      $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                      $urandom_range(32'h1000, 32'h4_0000),
                      $urandom_range(32'h1000, 32'h4_0000),
                      $urandom_range(1, 70), $urandom_range(1, 70),
                      $urandom_range(0, 1));
            random_phase(PHASE_ITEMS);
        end

        // back-to-back burst of heavy adds into one bin, then read it out
        configure(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd64, 32'd64, 32'd1);
        repeat (BURST_ADDS)
        begin
            c = particle(32'h8000_0000, 32'h7FFF_FFFF, $urandom,
                         3 * ONE, 5 * ONE, $urandom, 17'h1FFFF);
            c.gap = 0;
            enqueue(c);
        end
        enqueue(bin_read(7'd3, 7'd5));
        enqueue(blank_cmd(FUNC_READ_SUMS));
        enqueue(bin_read(7'd3, 7'd5));
        settle();

        $display("Ran %0d commands over %0d register settings (%0d writes); %0d results",
                 issued, settings_used + 1, reg_writes, results_seen);
        $display("checked, %0d particles landed in a bin, %0d mismatches",
                 bins_hit, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
